// File: rtl/core/assert_macros.svh
// Assertion macros shared by the blitter RTL.
// No dependencies; the assertion forms drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define RPBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define RPBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RPBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/core/rpbe_pkg.sv
// Shared constants, codes and stage structs for the rotated palette blitter.
// Used by every module of the block except rpbe_ram; depends on nothing.
`timescale 1ns / 1ps

package rpbe_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_DIM         = 2048;
  localparam int ADDR_BITS       = 24;

  localparam int PAL_AW      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CW          = 16;
  localparam int OFS_W       = 2 * DIM_W + 1;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic signed [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_W   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_H   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_PITCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_W    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_H    = 3'd6;

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_BLIT    = 2'd1,
    OP_PIXEL   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ORIENT_0   = 2'd0,
    ORIENT_90  = 2'd1,
    ORIENT_180 = 2'd2,
    ORIENT_270 = 2'd3
  } orient_e;

  typedef enum logic {
    KIND_DESC  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  // One input request, unpacked
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         index;
    logic [31:0]        color;
    logic signed [12:0] src_left;
    logic signed [12:0] src_top;
    logic signed [12:0] src_right;
    logic signed [12:0] src_bottom;
    logic signed [12:0] dst_x;
    logic signed [12:0] dst_y;
    logic [11:0]        src_width;
    logic [11:0]        src_height;
  } in_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [11:0]          log_w;
    logic [11:0]          log_h;
    logic [ADDR_BITS-1:0] origin;
    logic [ADDR_BITS-1:0] step_x;
    logic [ADDR_BITS-1:0] step_y;
  } cfg_t;

  // Clip stage register contents
  typedef struct packed {
    logic [1:0]           op;
    logic                 idx_ok;
    logic [31:0]          data;
    logic                 empty;
    logic [DIM_W-1:0]     cols;
    logic [DIM_W-1:0]     rows;
    logic [11:0]          skip;
    logic [DIM_W-1:0]     top;
    logic [DIM_W-1:0]     left;
    logic [DIM_W-1:0]     sw;
    logic [ADDR_BITS-1:0] py;
    logic [ADDR_BITS-1:0] px;
  } clip_t;

  // One result
  typedef struct packed {
    logic        kind;
    logic        empty_res;
    logic [23:0] addr;
    logic [31:0] data;
    logic [21:0] src_offset;
    logic [11:0] src_skip;
    logic [11:0] columns;
    logic [11:0] rows;
    logic        last;
  } res_t;

  // Status of the result stage
  typedef struct packed {
    logic fire;
    logic last_load;
    logic blit_active;
  } stat_t;

endpackage

// File: rtl/core/rpbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rpbe_cfg.sv
// Configuration registers plus the orientation origin and pitch steps derived from them.
// Depends on rpbe_pkg.
`timescale 1ns / 1ps

module rpbe_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpbe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rpbe_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output rpbe_pkg::cfg_t                      cfg_o
);

  localparam int AW = rpbe_pkg::ADDR_BITS;

  logic [1:0]  orient_q;
  logic [11:0] phys_w_q;
  logic [11:0] phys_h_q;
  logic [4:0]  x_pitch_q;
  logic [15:0] y_pitch_q;
  logic [11:0] log_w_q;
  logic [11:0] log_h_q;

  logic [AW-1:0] origin_d, origin_q;
  logic [AW-1:0] step_x_d, step_x_q;
  logic [AW-1:0] step_y_d, step_y_q;
  logic [AW-1:0] xp_e, yp_e, wm1, hm1, org_90, org_270;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q  <= 2'd0;
      phys_w_q  <= 12'd320;
      phys_h_q  <= 12'd480;
      x_pitch_q <= 5'd4;
      y_pitch_q <= 16'd1280;
      log_w_q   <= 12'd320;
      log_h_q   <= 12'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpbe_pkg::CFG_ORIENT:  orient_q  <= cfg_wdata_i[1:0];
        rpbe_pkg::CFG_PHYS_W:  phys_w_q  <= cfg_wdata_i[11:0];
        rpbe_pkg::CFG_PHYS_H:  phys_h_q  <= cfg_wdata_i[11:0];
        rpbe_pkg::CFG_X_PITCH: x_pitch_q <= cfg_wdata_i[4:0];
        rpbe_pkg::CFG_Y_PITCH: y_pitch_q <= cfg_wdata_i[15:0];
        rpbe_pkg::CFG_LOG_W:   log_w_q   <= cfg_wdata_i[11:0];
        rpbe_pkg::CFG_LOG_H:   log_h_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Origin and signed steps for the current rotation, modulo 2^AW
  always_comb begin
    xp_e    = AW'(x_pitch_q);
    yp_e    = AW'(y_pitch_q);
    wm1     = AW'(phys_w_q) - AW'(1);
    hm1     = AW'(phys_h_q) - AW'(1);
    org_90  = yp_e * hm1;
    org_270 = xp_e * wm1;
    case (rpbe_pkg::orient_e'(orient_q))
      rpbe_pkg::ORIENT_90: begin
        origin_d = org_90;
        step_x_d = -yp_e;
        step_y_d = xp_e;
      end
      rpbe_pkg::ORIENT_180: begin
        origin_d = org_90 + org_270;
        step_x_d = -xp_e;
        step_y_d = -yp_e;
      end
      rpbe_pkg::ORIENT_270: begin
        origin_d = org_270;
        step_x_d = yp_e;
        step_y_d = -xp_e;
      end
      default: begin
        origin_d = '0;
        step_x_d = xp_e;
        step_y_d = yp_e;
      end
    endcase
  end

  // Hold the derived values in registers to keep the multipliers off the datapath
  always_ff @(posedge clk_i) begin
    origin_q <= origin_d;
    step_x_q <= step_x_d;
    step_y_q <= step_y_d;
  end

  assign cfg_o.log_w  = log_w_q;
  assign cfg_o.log_h  = log_h_q;
  assign cfg_o.origin = origin_q;
  assign cfg_o.step_x = step_x_q;
  assign cfg_o.step_y = step_y_q;

endmodule

// File: rtl/core/rpbe_clip.sv
// Clip stage: clips the blit rectangle, forms destination offsets, registers the request.
// Depends on rpbe_pkg.
`timescale 1ns / 1ps

module rpbe_clip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                a_valid_i,
  input  rpbe_pkg::in_t       a_i,
  input  logic [31:0]         pal_rdata_i,
  input  rpbe_pkg::cfg_t      cfg_i,
  output logic                b_valid_o,
  output rpbe_pkg::clip_t     b_o
);

  localparam int CW = rpbe_pkg::CW;
  localparam int DW = rpbe_pkg::DIM_W;
  localparam int AW = rpbe_pkg::ADDR_BITS;

  logic signed [CW-1:0] sw, sh, lw, lh;
  logic signed [CW-1:0] l, t, r, b, dx, dy;
  logic signed [CW-1:0] l0, t0, r0, b0;
  logic signed [CW-1:0] l1, t1, dx1, dy1, r1, b1;
  logic signed [CW-1:0] cols, rws;
  logic                 idx_ok;
  rpbe_pkg::clip_t      clip_d;
  rpbe_pkg::clip_t      clip_q;
  logic                 b_valid_q;

  function automatic logic signed [CW-1:0] clamp_dim(input logic [11:0] v);
    logic signed [CW-1:0] x;
    x = signed'(CW'(v));
    return (x > rpbe_pkg::MAX_DIM_C) ? rpbe_pkg::MAX_DIM_C : x;
  endfunction

  // Clip against the source bitmap, then the logical screen
  always_comb begin
    sw = clamp_dim(a_i.src_width);
    sh = clamp_dim(a_i.src_height);
    lw = clamp_dim(cfg_i.log_w);
    lh = clamp_dim(cfg_i.log_h);
    l  = CW'($signed(a_i.src_left));
    t  = CW'($signed(a_i.src_top));
    r  = CW'($signed(a_i.src_right));
    b  = CW'($signed(a_i.src_bottom));
    dx = CW'($signed(a_i.dst_x));
    dy = CW'($signed(a_i.dst_y));

    l0 = l[CW-1] ? '0 : l;
    t0 = t[CW-1] ? '0 : t;
    r0 = (r > sw) ? sw : r;
    b0 = (b > sh) ? sh : b;

    l1  = dx[CW-1] ? l0 - dx : l0;
    dx1 = dx[CW-1] ? '0 : dx;
    t1  = dy[CW-1] ? t0 - dy : t0;
    dy1 = dy[CW-1] ? '0 : dy;

    r1 = (dx1 + (r0 - l1) > lw) ? lw - dx1 + l1 : r0;
    b1 = (dy1 + (b0 - t1) > lh) ? lh - dy1 + t1 : b0;

    cols = r1 - l1;
    rws  = b1 - t1;

    idx_ok = {1'b0, a_i.index} < 9'(rpbe_pkg::PALETTE_ENTRIES);

    clip_d.op     = a_i.op;
    clip_d.idx_ok = idx_ok;
    clip_d.data   = idx_ok ? pal_rdata_i : 32'd0;
    clip_d.empty  = (r1 <= l1) || (b1 <= t1);
    clip_d.cols   = DW'(cols);
    clip_d.rows   = DW'(rws);
    clip_d.skip   = 12'(sw - cols);
    clip_d.top    = DW'(t1);
    clip_d.left   = DW'(l1);
    clip_d.sw     = DW'(sw);
    // Destination offsets from the clipped destination corner
    clip_d.py     = AW'($unsigned(dy1)) * cfg_i.step_y;
    clip_d.px     = AW'($unsigned(dx1)) * cfg_i.step_x;
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en_i && a_valid_i) begin
      clip_q <= clip_d;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_o       = clip_q;

endmodule

// File: rtl/core/rpbe_emit.sv
// Result stage: blit state, pixel address stepping and the output register.
// Depends on rpbe_pkg.
`timescale 1ns / 1ps

module rpbe_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               b_valid_i,
  input  rpbe_pkg::clip_t    b_i,
  input  rpbe_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output rpbe_pkg::res_t     res_o,
  output rpbe_pkg::stat_t    stat_o
);

  localparam int AW = rpbe_pkg::ADDR_BITS;
  localparam int DW = rpbe_pkg::DIM_W;
  localparam int OW = rpbe_pkg::OFS_W;

  logic          loaded_d, loaded_q;
  logic          active_d, active_q;
  logic [DW-1:0] col_d, col_q, row_d, row_q;
  logic [DW-1:0] ncols_d, ncols_q, nrows_d, nrows_q;
  logic [AW-1:0] row_addr_d, row_addr_q, pix_addr_d, pix_addr_q;
  logic [AW-1:0] sx_d, sx_q, sy_d, sy_q;
  logic [AW-1:0] first, row_next;
  logic [DW-1:0] col_inc, row_inc;
  logic [OW-1:0] ofs;
  logic          has_res, fire;
  rpbe_pkg::res_t res_d, res_q;
  logic          res_valid_q;

  assign fire = b_valid_i && en_i;

  always_comb begin
    loaded_d   = loaded_q;
    active_d   = active_q;
    col_d      = col_q;
    row_d      = row_q;
    ncols_d    = ncols_q;
    nrows_d    = nrows_q;
    row_addr_d = row_addr_q;
    pix_addr_d = pix_addr_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    res_d      = '0;
    has_res    = 1'b0;

    first    = cfg_i.origin + b_i.py + b_i.px;
    ofs      = OW'(b_i.top) * OW'(b_i.sw) + OW'(b_i.left);
    col_inc  = col_q + DW'(1);
    row_inc  = row_q + DW'(1);
    row_next = row_addr_q + sy_q;

    case (b_i.op)
      rpbe_pkg::OP_PALETTE: begin
        if (b_i.idx_ok) begin
          loaded_d = 1'b1;
        end
      end
      rpbe_pkg::OP_BLIT: begin
        // Start or restart a blit; any running one is dropped
        has_res    = 1'b1;
        res_d.kind = rpbe_pkg::KIND_DESC;
        active_d   = 1'b0;
        if (b_i.empty || !loaded_q) begin
          res_d.empty_res = 1'b1;
        end else begin
          res_d.src_offset = 22'(ofs);
          res_d.src_skip   = b_i.skip;
          res_d.columns    = 12'(b_i.cols);
          res_d.rows       = 12'(b_i.rows);
          active_d   = 1'b1;
          col_d      = '0;
          row_d      = '0;
          ncols_d    = b_i.cols;
          nrows_d    = b_i.rows;
          row_addr_d = first;
          pix_addr_d = first;
          sx_d       = cfg_i.step_x;
          sy_d       = cfg_i.step_y;
        end
      end
      rpbe_pkg::OP_PIXEL: begin
        if (active_q) begin
          has_res    = 1'b1;
          res_d.kind = rpbe_pkg::KIND_PIXEL;
          res_d.addr = 24'(pix_addr_q);
          res_d.data = b_i.data;
          col_d      = col_inc;
          pix_addr_d = pix_addr_q + sx_q;
          // Advance to the next row at the end of one
          if (col_inc >= ncols_q) begin
            col_d      = '0;
            row_d      = row_inc;
            row_addr_d = row_next;
            pix_addr_d = row_next;
            if (row_inc >= nrows_q) begin
              active_d   = 1'b0;
              res_d.last = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Blit control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= 1'b0;
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      ncols_q    <= '0;
      nrows_q    <= '0;
      row_addr_q <= '0;
      pix_addr_q <= '0;
    end else if (fire) begin
      loaded_q   <= loaded_d;
      active_q   <= active_d;
      col_q      <= col_d;
      row_q      <= row_d;
      ncols_q    <= ncols_d;
      nrows_q    <= nrows_d;
      row_addr_q <= row_addr_d;
      pix_addr_q <= pix_addr_d;
    end
  end

  // Steps latched at blit start
  always_ff @(posedge clk_i) begin
    if (fire) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en_i) begin
      res_valid_q <= fire && has_res;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign res_o              = res_q;
  assign stat_o.fire        = fire;
  assign stat_o.last_load   = fire && has_res && res_d.last;
  assign stat_o.blit_active = active_q;

endmodule

// File: rtl/core/rotated_palette_blit_engine.sv
// Rotated palette blitter top level: input register, palette RAM, clip and result stages.
// A request passes the input, clip and output registers in order; output stalls hold it.
// Throughput: one request per cycle unless stalled; the RAM read and clip stage pipeline it.
// Reset (rst_ni low, asynchronous) clears stage valids and blit state; the palette holds
// whatever was written and is not cleared. Depends on rpbe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotated_palette_blit_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rpbe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rpbe_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // index, color, src_left, src_top, src_right, src_bottom, dst_x, dst_y,
  // src_width, src_height (from bit 0 up)
  input  logic [rpbe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // op
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // empty_res, addr, data, src_offset, src_skip, columns, rows (from bit 0 up)
  output logic [rpbe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // kind
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  rpbe_pkg::in_t   s_in;
  rpbe_pkg::in_t   a_q;
  logic            a_valid_q;
  logic            accept, pal_we;
  logic            en_out, en_b, en_a;
  logic            b_valid;
  rpbe_pkg::clip_t b_item;
  rpbe_pkg::cfg_t  cfg;
  rpbe_pkg::res_t  res;
  rpbe_pkg::stat_t stat;
  logic [31:0]     pal_rdata;

  // Unpack the request
  assign s_in.op         = s_axis_tuser;
  assign s_in.index      = s_axis_tdata[7:0];
  assign s_in.color      = s_axis_tdata[39:8];
  assign s_in.src_left   = s_axis_tdata[52:40];
  assign s_in.src_top    = s_axis_tdata[65:53];
  assign s_in.src_right  = s_axis_tdata[78:66];
  assign s_in.src_bottom = s_axis_tdata[91:79];
  assign s_in.dst_x      = s_axis_tdata[104:92];
  assign s_in.dst_y      = s_axis_tdata[117:105];
  assign s_in.src_width  = s_axis_tdata[129:118];
  assign s_in.src_height = s_axis_tdata[141:130];

  // Stage enables, each stage moves when the one after it has room
  assign en_out        = !m_axis_tvalid || m_axis_tready;
  assign en_b          = !b_valid || en_out;
  assign en_a          = !a_valid_q || en_b;
  assign s_axis_tready = en_a;
  assign accept        = s_axis_tvalid && en_a;
  assign pal_we        = accept && (s_in.op == rpbe_pkg::OP_PALETTE) &&
                         ({1'b0, s_in.index} < 9'(rpbe_pkg::PALETTE_ENTRIES));

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_a) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= s_in;
    end
  end

  // Palette: written and read in request order at accept time
  rpbe_ram #(
    .WIDTH (32),
    .DEPTH (rpbe_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (s_in.index[rpbe_pkg::PAL_AW-1:0]),
    .wdata_i (s_in.color),
    .re_i    (accept),
    .raddr_i (s_in.index[rpbe_pkg::PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  rpbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rpbe_clip u_clip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_b),
    .a_valid_i   (a_valid_q),
    .a_i         (a_q),
    .pal_rdata_i (pal_rdata),
    .cfg_i       (cfg),
    .b_valid_o   (b_valid),
    .b_o         (b_item)
  );

  rpbe_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_out),
    .b_valid_i   (b_valid),
    .b_i         (b_item),
    .cfg_i       (cfg),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .stat_o      (stat)
  );

  // Pack the result
  assign m_axis_tdata = {5'd0, res.rows, res.columns, res.src_skip, res.src_offset,
                         res.data, res.addr, res.empty_res};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // Checks
  `RPBE_ASSERT_IMP(a_last_on_pixel, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
    m_axis_tuser == rpbe_pkg::KIND_PIXEL, "last flag on a descriptor")
  `RPBE_ASSERT_IMP(a_empty_desc_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == rpbe_pkg::KIND_DESC) && m_axis_tdata[0],
    m_axis_tdata[114:91] == 24'd0, "empty descriptor carries counts")
  `RPBE_ASSERT_IMP(a_full_desc_counts, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == rpbe_pkg::KIND_DESC) && !m_axis_tdata[0],
    (m_axis_tdata[102:91] != 12'd0) && (m_axis_tdata[114:103] != 12'd0),
    "non-empty descriptor with zero columns or rows")
  `RPBE_ASSERT_NXT(a_last_ends_blit, clk_i, rst_ni, stat.fire && stat.last_load,
    !stat.blit_active, "blit still active after its last pixel")

endmodule
